// File: src/dmc_pkg.sv
// ============================================================================
// dmc_pkg: shared definitions for the direct-mapped write-back cache
// Geometry constants, field widths, request kind codes and the command and
// status bundles that pass between the controller and the datapath.
// ============================================================================
package dmc_pkg;

  // Cache and memory geometry. The memory spans the whole address space, so
  // every memory address is simply the address bits.
  localparam int LINES          = 8;
  localparam int WORDS_PER_LINE = 4;
  localparam int MEMORY_WORDS   = 256;

  localparam int KIND_W  = 2;
  localparam int ADDR_W  = 8;
  localparam int DATA_W  = 32;
  localparam int OFF_W   = $clog2(WORDS_PER_LINE);
  localparam int IDX_W   = $clog2(LINES);
  localparam int TAG_W   = ADDR_W - OFF_W - IDX_W;
  localparam int LINE_AW = IDX_W + OFF_W;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DIRECT = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load_req;   // capture the accepted request
    logic              lookup;     // record hit and write-back flags
    logic              evict;      // read one victim word for write-back
    logic              fill_rd;    // read one memory word for the line fill
    logic              install;    // mark the line valid with the new tag
    logic              acc;        // perform the word access
    logic              clear_wr;   // zero one memory word after reset
    logic              load_out;   // load the result register
    logic [ADDR_W-1:0] cnt;        // word or memory counter
  } dmc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cached;
    logic hit;
    logic victim_valid;
  } dmc_sts_t;

endpackage

// File: src/dmc_if.sv
// ============================================================================
// dmc_if: valid/ready channels of the cache
// One interface for the request channel and one for the result channel.
// ============================================================================
interface dmc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [7:0]         address;
  logic signed [31:0] write_data;

  modport source (output valid, output kind, output address, output write_data,
                  input ready);
  modport sink (input valid, input kind, input address, input write_data,
                output ready);
endinterface

interface dmc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_data;
  logic               hit;
  logic               wrote_back;

  modport source (output valid, output read_data, output hit, output wrote_back,
                  input ready);
  modport sink (input valid, input read_data, input hit, input wrote_back,
                output ready);
endinterface

// File: src/dmc_ctrl.sv
// ============================================================================
// dmc_ctrl: cache controller
// Sequences the memory clearing pass, lookup, write-back, fill, access and
// result hand-off, and owns the handshake flags of both channels.
// ============================================================================
module dmc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  dmc_pkg::dmc_sts_t sts,
  output dmc_pkg::dmc_cmd_t cmd
);
  import dmc_pkg::*;

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_LOOKUP  = 3'd2;
  localparam logic [2:0] S_EVICT   = 3'd3;
  localparam logic [2:0] S_FILL    = 3'd4;
  localparam logic [2:0] S_INSTALL = 3'd5;
  localparam logic [2:0] S_ACCESS  = 3'd6;
  localparam logic [2:0] S_RESP    = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              word_last;

  assign word_last = (cnt_r[OFF_W-1:0] == OFF_W'(WORDS_PER_LINE - 1));

  always_comb begin
    cmd       = '0;
    cmd.cnt   = cnt_r;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        cnt_nxt      = cnt_r + ADDR_W'(1);
        if (&cnt_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        cnt_nxt    = '0;
        if (sts.cached && !sts.hit) begin
          state_nxt = sts.victim_valid ? S_EVICT : S_FILL;
        end else begin
          state_nxt = S_ACCESS;
        end
      end
      S_EVICT: begin
        cmd.evict = 1'b1;
        if (word_last) begin
          cnt_nxt   = '0;
          state_nxt = S_FILL;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      S_FILL: begin
        cmd.fill_rd = 1'b1;
        if (word_last) begin
          cnt_nxt   = '0;
          state_nxt = S_INSTALL;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      S_INSTALL: begin
        cmd.install = 1'b1;
        state_nxt   = S_ACCESS;
      end
      S_ACCESS: begin
        cmd.acc   = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.load_out | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: src/dmc_dp.sv
// ============================================================================
// dmc_dp: cache datapath
// Holds the request, the line tags and valid bits, the line word memory, the
// backing memory and the result register.
// ============================================================================
module dmc_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dmc_pkg::dmc_cmd_t                 cmd,
  output dmc_pkg::dmc_sts_t                 sts,
  input  logic [dmc_pkg::KIND_W-1:0]        in_kind,
  input  logic [dmc_pkg::ADDR_W-1:0]        in_address,
  input  logic signed [dmc_pkg::DATA_W-1:0] in_write_data,
  output logic signed [dmc_pkg::DATA_W-1:0] out_read_data,
  output logic                              out_hit,
  output logic                              out_wrote_back
);
  import dmc_pkg::*;

  logic [KIND_W-1:0]        kind_r;
  logic [ADDR_W-1:0]        addr_r;
  logic signed [DATA_W-1:0] wdata_r;
  logic                     hit_r;
  logic                     wb_r;

  logic [LINES-1:0]         valid_r;
  logic [TAG_W-1:0]         tag_r [LINES];

  logic [DATA_W-1:0]        line_ram_r [LINES*WORDS_PER_LINE];
  logic [DATA_W-1:0]        back_ram_r [MEMORY_WORDS];
  logic [DATA_W-1:0]        line_q_r;
  logic [DATA_W-1:0]        back_q_r;

  logic                     wb_pend_r;
  logic                     fill_pend_r;
  logic [OFF_W-1:0]         wb_word_r;
  logic [OFF_W-1:0]         fill_word_r;

  logic signed [DATA_W-1:0] rdata_r;
  logic                     out_hit_r;
  logic                     out_wb_r;

  logic [OFF_W-1:0]         off;
  logic [IDX_W-1:0]         idx;
  logic [TAG_W-1:0]         tag;
  logic [OFF_W-1:0]         word;
  logic [LINE_AW-1:0]       line_rd_addr;
  logic [ADDR_W-1:0]        back_rd_addr;
  logic [DATA_W-1:0]        rdata_sel;

  assign off  = addr_r[OFF_W-1:0];
  assign idx  = addr_r[OFF_W +: IDX_W];
  assign tag  = addr_r[ADDR_W-1 -: TAG_W];
  assign word = cmd.cnt[OFF_W-1:0];

  assign sts.cached       = (kind_r == KIND_READ) || (kind_r == KIND_WRITE);
  assign sts.victim_valid = valid_r[idx];
  assign sts.hit          = valid_r[idx] && (tag_r[idx] == tag);

  // Outside of write-back and fill the read ports sit on the requested word,
  // so the read data stays put while a result waits.
  assign line_rd_addr = cmd.evict   ? {idx, word}      : {idx, off};
  assign back_rd_addr = cmd.fill_rd ? {tag, idx, word} : addr_r;

  always_comb begin
    case (kind_r)
      KIND_READ:   rdata_sel = line_q_r;
      KIND_DIRECT: rdata_sel = back_q_r;
      default:     rdata_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      kind_r  <= in_kind;
      addr_r  <= in_address;
      wdata_r <= in_write_data;
    end
    if (cmd.lookup) begin
      hit_r <= sts.cached && sts.hit;
      wb_r  <= sts.cached && !sts.hit && sts.victim_valid;
    end
    wb_word_r   <= word;
    fill_word_r <= word;
    if (cmd.load_out) begin
      rdata_r   <= $signed(rdata_sel);
      out_hit_r <= hit_r;
      out_wb_r  <= wb_r;
    end
  end

  // Line word memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    line_q_r <= line_ram_r[line_rd_addr];
    if (fill_pend_r) begin
      line_ram_r[{idx, fill_word_r}] <= back_q_r;
    end else if (cmd.acc && (kind_r == KIND_WRITE)) begin
      line_ram_r[{idx, off}] <= $unsigned(wdata_r);
    end
  end

  // Backing memory: one write port, one registered read port. The victim tag
  // is still in place while its words are written back.
  always_ff @(posedge clk) begin
    back_q_r <= back_ram_r[back_rd_addr];
    if (cmd.clear_wr) begin
      back_ram_r[cmd.cnt] <= '0;
    end else if (wb_pend_r) begin
      back_ram_r[{tag_r[idx], idx, wb_word_r}] <= line_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_pend_r   <= 1'b0;
      fill_pend_r <= 1'b0;
      valid_r     <= '0;
      tag_r       <= '{default: '0};
    end else begin
      wb_pend_r   <= cmd.evict;
      fill_pend_r <= cmd.fill_rd;
      if (cmd.install) begin
        valid_r[idx] <= 1'b1;
        tag_r[idx]   <= tag;
      end
    end
  end

  assign out_read_data  = rdata_r;
  assign out_hit        = out_hit_r;
  assign out_wrote_back = out_wb_r;

endmodule

// File: src/direct_mapped_write_back_cache_core.sv
// ============================================================================
// direct_mapped_write_back_cache_core: direct-mapped write-back data cache
// Cache of 8 lines of 4 words in front of a 256-word backing memory that
// lives inside the block, with cached reads, cached writes and direct reads.
// ============================================================================
// Sequence: a hit, a direct read or an unused kind goes from the request
// transfer through lookup and the word access to the result; a miss also
// writes back a valid victim and fills the line, one memory word per cycle.
// Requests are taken one at a time; the next waits until the block is idle.
// Reset: synchronous; a pass then zeroes all 256 backing memory words, and
// no request is taken until it ends. Line valid bits and tags clear at once.
// ============================================================================
module direct_mapped_write_back_cache_core (
  input logic       clk,
  input logic       rst_n,
  dmc_in_if.sink    in_ch,
  dmc_out_if.source out_ch
);
  import dmc_pkg::*;

  // The controller walks the request through lookup, optional write-back of
  // the victim, optional fill, the word access and the result hand-off. Both
  // memories have registered read ports, so write-back and fill each run one
  // word per cycle, each word written in the cycle after it is read.
  dmc_cmd_t cmd;
  dmc_sts_t sts;

  dmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds every store and the result register, which lets a
  // finished result wait for the sink while the controller returns to idle.
  dmc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_kind        (in_ch.kind),
    .in_address     (in_ch.address),
    .in_write_data  (in_ch.write_data),
    .out_read_data  (out_ch.read_data),
    .out_hit        (out_ch.hit),
    .out_wrote_back (out_ch.wrote_back)
  );

  // At most one datapath operation is commanded in any cycle.
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_req, cmd.lookup, cmd.evict, cmd.fill_rd, cmd.install,
              cmd.acc, cmd.clear_wr, cmd.load_out}))
    else $error("more than one datapath command at once");

  // A hit never writes back a victim.
  a_hit_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.hit && out_ch.wrote_back))
    else $error("result reports both hit and write-back");

  // Once a request is taken, the next one waits until this one is finished.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while another is in progress");

endmodule
